>>> rtl/vsa_pkg.sv
// ----------------------------------------------------------------------------
// vsa_pkg
// Types, command codes and saturation helpers for the voice slot allocator.
// ----------------------------------------------------------------------------
package vsa_pkg;

    localparam int VOICE_COUNT   = 16;
    localparam int SOUND_ID_BITS = 8;

    // sound identity is compared in the low bits that the input field carries
    localparam int SND_W = (SOUND_ID_BITS < 8) ? SOUND_ID_BITS : 8;
    localparam int IDX_W = $clog2(VOICE_COUNT);
    localparam int CNT_W = $clog2(VOICE_COUNT + 1);

    localparam logic [2:0] KIND_ONESHOT  = 3'd0;
    localparam logic [2:0] KIND_LOOP     = 3'd1;
    localparam logic [2:0] KIND_STOP_ALL = 3'd2;
    localparam logic [2:0] KIND_STOP_NEW = 3'd3;
    localparam logic [2:0] KIND_VOLUME   = 3'd4;
    localparam logic [2:0] KIND_PAN      = 3'd5;
    localparam logic [2:0] KIND_RESET    = 3'd6;
    localparam logic [2:0] KIND_FINISHED = 3'd7;

    localparam logic signed [12:0] VOL_MIN = -13'sd4000;
    localparam logic signed [12:0] VOL_MAX = 13'sd0;
    localparam logic signed [10:0] PAN_MIN = -11'sd1000;
    localparam logic signed [10:0] PAN_MAX = 11'sd1000;

    typedef struct packed {
        logic [SND_W-1:0]   snd;
        logic [31:0]        stamp;
        logic signed [12:0] vol;
        logic signed [10:0] pan;
    } voice_entry_t;

    function automatic logic signed [12:0] clamp_vol(input logic signed [12:0] v);
        logic signed [12:0] r;
        if (v < VOL_MIN)
            r = VOL_MIN;
        else if (v > VOL_MAX)
            r = VOL_MAX;
        else
            r = v;
        return r;
    endfunction

    function automatic logic signed [10:0] clamp_pan(input logic signed [10:0] v);
        logic signed [10:0] r;
        if (v < PAN_MIN)
            r = PAN_MIN;
        else if (v > PAN_MAX)
            r = PAN_MAX;
        else
            r = v;
        return r;
    endfunction

endpackage

>>> rtl/voice_slot_allocator.sv
// ----------------------------------------------------------------------------
// voice_slot_allocator
// Command-driven voice table: play, stop, volume, pan, reset and finished.
//
// Input channel (in_valid/in_stall) carries one command word; the output
// channel (out_valid/out_stall) returns exactly one result word per command.
// Voice data (sound, age stamp, volume, pan) sits in a single-port-write,
// registered-read memory; active and loop marks are flip-flops.
// Every command except "finished" scans the table one entry per cycle through
// the registered memory read port, then loads its result in the finish state;
// a finished event goes from accept straight to the finish state. One command
// is in work at a time: in_stall is high from accept until its result is
// loaded into the output register.
// The result register holds its word while out_stall is high; the next
// command is accepted meanwhile, and its result waits until the register
// frees up. Reset clears all voices, the stamp counter and the output valid;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module voice_slot_allocator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         kind,
    input  logic [7:0]         sound_id,
    input  logic [4:0]         max_polyphony,
    input  logic signed [12:0] volume,
    input  logic signed [10:0] pan,
    input  logic [3:0]         voice_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         slot,
    output logic               slot_valid,
    output logic               replaced_active,
    output logic [4:0]         voices_affected,
    output logic signed [12:0] slot_volume,
    output logic signed [10:0] slot_pan
);

    localparam int IDX_W = vsa_pkg::IDX_W;
    localparam int CNT_W = vsa_pkg::CNT_W;
    localparam int SND_W = vsa_pkg::SND_W;
    localparam int VC    = vsa_pkg::VOICE_COUNT;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // control
    logic [1:0]            state_reg, state_next;
    logic [VC-1:0]         active_reg, active_next;
    logic [VC-1:0]         looping_reg, looping_next;
    logic [31:0]           stamp_cnt_reg, stamp_cnt_next;
    logic [CNT_W-1:0]      rd_cnt_reg, rd_cnt_next;
    logic                  proc_vld_reg, proc_vld_next;
    logic [IDX_W-1:0]      proc_idx_reg, proc_idx_next;
    logic                  out_valid_reg, out_valid_next;

    // captured command
    logic [2:0]            kind_reg, kind_next;
    logic [SND_W-1:0]      snd_reg, snd_next;
    logic [4:0]            limit_reg, limit_next;
    logic signed [12:0]    vol_reg, vol_next;
    logic signed [10:0]    pan_reg, pan_next;
    logic [3:0]            vidx_reg, vidx_next;

    // scan trackers
    logic [CNT_W-1:0]      match_cnt_reg, match_cnt_next;
    logic [CNT_W-1:0]      act_cnt_reg, act_cnt_next;
    logic                  sel_found_reg, sel_found_next;
    logic [IDX_W-1:0]      sel_idx_reg, sel_idx_next;
    logic [31:0]           sel_stamp_reg, sel_stamp_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic                  oact_found_reg, oact_found_next;
    logic [IDX_W-1:0]      oact_idx_reg, oact_idx_next;
    logic [31:0]           oact_stamp_reg, oact_stamp_next;
    logic                  loop_found_reg, loop_found_next;
    logic [IDX_W-1:0]      loop_idx_reg, loop_idx_next;
    logic [31:0]           loop_stamp_reg, loop_stamp_next;

    // result word
    logic [3:0]            slot_reg, slot_next;
    logic                  slot_valid_reg, slot_valid_next;
    logic                  replaced_reg, replaced_next;
    logic [4:0]            affected_reg, affected_next;
    logic signed [12:0]    ovol_reg, ovol_next;
    logic signed [10:0]    opan_reg, opan_next;

    // voice memory
    vsa_pkg::voice_entry_t mem [VC];
    vsa_pkg::voice_entry_t rd_data;
    vsa_pkg::voice_entry_t mem_wd;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_wa;
    logic [IDX_W-1:0]      rd_addr;

    logic                  accept;
    logic                  out_free;
    logic                  act_i;
    logic                  loop_i;
    logic                  hit;
    logic                  sel_better;
    logic [IDX_W-1:0]      pick;
    logic [IDX_W-1:0]      fin_idx;
    logic                  fin_ok;

    assign in_stall        = (state_reg != ST_IDLE);
    assign accept          = in_valid && !in_stall;
    assign out_free        = !out_valid_reg || !out_stall;
    assign rd_addr         = rd_cnt_reg[IDX_W-1:0];

    assign out_valid       = out_valid_reg;
    assign slot            = slot_reg;
    assign slot_valid      = slot_valid_reg;
    assign replaced_active = replaced_reg;
    assign voices_affected = affected_reg;
    assign slot_volume     = ovol_reg;
    assign slot_pan        = opan_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data <= mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        looping_next    = looping_reg;
        stamp_cnt_next  = stamp_cnt_reg;
        rd_cnt_next     = rd_cnt_reg;
        proc_vld_next   = 1'b0;
        proc_idx_next   = proc_idx_reg;
        out_valid_next  = out_valid_reg && out_stall;

        kind_next       = kind_reg;
        snd_next        = snd_reg;
        limit_next      = limit_reg;
        vol_next        = vol_reg;
        pan_next        = pan_reg;
        vidx_next       = vidx_reg;

        match_cnt_next  = match_cnt_reg;
        act_cnt_next    = act_cnt_reg;
        sel_found_next  = sel_found_reg;
        sel_idx_next    = sel_idx_reg;
        sel_stamp_next  = sel_stamp_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        oact_found_next = oact_found_reg;
        oact_idx_next   = oact_idx_reg;
        oact_stamp_next = oact_stamp_reg;
        loop_found_next = loop_found_reg;
        loop_idx_next   = loop_idx_reg;
        loop_stamp_next = loop_stamp_reg;

        slot_next       = slot_reg;
        slot_valid_next = slot_valid_reg;
        replaced_next   = replaced_reg;
        affected_next   = affected_reg;
        ovol_next       = ovol_reg;
        opan_next       = opan_reg;

        mem_we          = 1'b0;
        mem_wa          = proc_idx_reg;
        mem_wd          = rd_data;

        act_i      = active_reg[proc_idx_reg];
        loop_i     = looping_reg[proc_idx_reg];
        hit        = act_i && (rd_data.snd == snd_reg);
        sel_better = (kind_reg == vsa_pkg::KIND_STOP_NEW) ?
                     (rd_data.stamp > sel_stamp_reg) : (rd_data.stamp < sel_stamp_reg);

        // slot choice for a play command
        if ((32'(match_cnt_reg) >= 32'(limit_reg)) && sel_found_reg)
            pick = sel_idx_reg;
        else if (free_found_reg)
            pick = free_idx_reg;
        else if (oact_found_reg)
            pick = oact_idx_reg;
        else
            pick = '0;

        fin_ok  = 32'(vidx_reg) < 32'(VC);
        fin_idx = IDX_W'(vidx_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next       = kind;
                    snd_next        = SND_W'(sound_id);
                    limit_next      = (max_polyphony == 5'd0) ? 5'd1 : max_polyphony;
                    vol_next        = vsa_pkg::clamp_vol(volume);
                    pan_next        = vsa_pkg::clamp_pan(pan);
                    vidx_next       = voice_index;
                    match_cnt_next  = '0;
                    act_cnt_next    = '0;
                    sel_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    oact_found_next = 1'b0;
                    loop_found_next = 1'b0;
                    rd_cnt_next     = '0;
                    state_next      = (kind == vsa_pkg::KIND_FINISHED) ? ST_FINISH : ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (32'(rd_cnt_reg) < 32'(VC))
                begin
                    rd_cnt_next   = CNT_W'(32'(rd_cnt_reg) + 32'd1);
                    proc_vld_next = 1'b1;
                    proc_idx_next = rd_addr;
                end

                // one entry per cycle, memory data arrives the cycle after its address
                if (proc_vld_reg)
                begin
                    if (!act_i)
                    begin
                        if (!free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = proc_idx_reg;
                        end
                    end
                    else
                    begin
                        act_cnt_next = CNT_W'(32'(act_cnt_reg) + 32'd1);
                        if (!oact_found_reg || (rd_data.stamp < oact_stamp_reg))
                        begin
                            oact_found_next = 1'b1;
                            oact_idx_next   = proc_idx_reg;
                            oact_stamp_next = rd_data.stamp;
                        end
                    end

                    if (hit)
                    begin
                        match_cnt_next = CNT_W'(32'(match_cnt_reg) + 32'd1);
                        if (!sel_found_reg || sel_better)
                        begin
                            sel_found_next = 1'b1;
                            sel_idx_next   = proc_idx_reg;
                            sel_stamp_next = rd_data.stamp;
                        end
                        if (loop_i && !loop_found_reg)
                        begin
                            loop_found_next = 1'b1;
                            loop_idx_next   = proc_idx_reg;
                            loop_stamp_next = rd_data.stamp;
                        end
                    end

                    case (kind_reg)
                        vsa_pkg::KIND_STOP_ALL:
                        begin
                            if (hit)
                            begin
                                active_next[proc_idx_reg]  = 1'b0;
                                looping_next[proc_idx_reg] = 1'b0;
                            end
                        end
                        vsa_pkg::KIND_VOLUME:
                        begin
                            if (hit)
                            begin
                                mem_we     = 1'b1;
                                mem_wd.vol = vol_reg;
                            end
                        end
                        vsa_pkg::KIND_PAN:
                        begin
                            if (hit)
                            begin
                                mem_we     = 1'b1;
                                mem_wd.pan = pan_reg;
                            end
                        end
                        vsa_pkg::KIND_RESET:
                        begin
                            active_next[proc_idx_reg]  = 1'b0;
                            looping_next[proc_idx_reg] = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase

                    if (proc_idx_reg == IDX_W'(VC - 1))
                        state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    slot_next       = 4'd0;
                    slot_valid_next = 1'b0;
                    replaced_next   = 1'b0;
                    affected_next   = 5'd0;
                    ovol_next       = '0;
                    opan_next       = '0;
                    state_next      = ST_IDLE;

                    case (kind_reg) inside
                        vsa_pkg::KIND_ONESHOT, vsa_pkg::KIND_LOOP:
                        begin
                            slot_valid_next = 1'b1;
                            affected_next   = 5'd1;
                            ovol_next       = vol_reg;
                            opan_next       = pan_reg;
                            mem_we          = 1'b1;
                            mem_wd.snd      = snd_reg;
                            mem_wd.vol      = vol_reg;
                            mem_wd.pan      = pan_reg;
                            if ((kind_reg == vsa_pkg::KIND_LOOP) && loop_found_reg)
                            begin
                                // looping voice already running: refresh level and pan only
                                mem_wa       = loop_idx_reg;
                                mem_wd.stamp = loop_stamp_reg;
                                slot_next    = 4'(loop_idx_reg);
                            end
                            else
                            begin
                                mem_wa              = pick;
                                mem_wd.stamp        = stamp_cnt_reg;
                                stamp_cnt_next      = stamp_cnt_reg + 32'd1;
                                replaced_next       = active_reg[pick];
                                active_next[pick]   = 1'b1;
                                looping_next[pick]  = (kind_reg == vsa_pkg::KIND_LOOP);
                                slot_next           = 4'(pick);
                            end
                        end
                        vsa_pkg::KIND_STOP_ALL, vsa_pkg::KIND_VOLUME, vsa_pkg::KIND_PAN:
                        begin
                            affected_next = 5'(match_cnt_reg);
                        end
                        vsa_pkg::KIND_RESET:
                        begin
                            affected_next = 5'(act_cnt_reg);
                        end
                        vsa_pkg::KIND_STOP_NEW:
                        begin
                            if (sel_found_reg)
                            begin
                                active_next[sel_idx_reg]  = 1'b0;
                                looping_next[sel_idx_reg] = 1'b0;
                                affected_next             = 5'd1;
                            end
                        end
                        default:
                        begin
                            // finished event: a looping voice stays active instead
                            if (fin_ok && active_reg[fin_idx] && !looping_reg[fin_idx])
                            begin
                                active_next[fin_idx] = 1'b0;
                                affected_next        = 5'd1;
                            end
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            looping_reg   <= '0;
            stamp_cnt_reg <= '0;
            rd_cnt_reg    <= '0;
            proc_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            looping_reg   <= looping_next;
            stamp_cnt_reg <= stamp_cnt_next;
            rd_cnt_reg    <= rd_cnt_next;
            proc_vld_reg  <= proc_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_idx_reg    <= proc_idx_next;
        kind_reg        <= kind_next;
        snd_reg         <= snd_next;
        limit_reg       <= limit_next;
        vol_reg         <= vol_next;
        pan_reg         <= pan_next;
        vidx_reg        <= vidx_next;
        match_cnt_reg   <= match_cnt_next;
        act_cnt_reg     <= act_cnt_next;
        sel_found_reg   <= sel_found_next;
        sel_idx_reg     <= sel_idx_next;
        sel_stamp_reg   <= sel_stamp_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        oact_found_reg  <= oact_found_next;
        oact_idx_reg    <= oact_idx_next;
        oact_stamp_reg  <= oact_stamp_next;
        loop_found_reg  <= loop_found_next;
        loop_idx_reg    <= loop_idx_next;
        loop_stamp_reg  <= loop_stamp_next;
        slot_reg        <= slot_next;
        slot_valid_reg  <= slot_valid_next;
        replaced_reg    <= replaced_next;
        affected_reg    <= affected_next;
        ovol_reg        <= ovol_next;
        opan_reg        <= opan_next;
    end

endmodule
